### rtl/mft_pkg.sv
// Shared types, constants and modular helpers for the modular Fenwick tree.
// No dependencies; mft_walker and modular_fenwick_tree import this package.
package mft_pkg;

	localparam int CAPACITY = 2048;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = IDX_W + 1;
	localparam int DATA_W   = 30;
	localparam int SIZE_W   = 12;
	localparam int ACT_W    = 2;

	localparam logic [DATA_W-1:0] MODULUS       = DATA_W'(1000000007);
	localparam logic [SIZE_W-1:0] TREE_SIZE_RST = SIZE_W'(2048);

	localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_Q_HI,
		ST_Q_LO,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [IDX_W-1:0]  index_a;
		logic [IDX_W-1:0]  index_b;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] range_sum;
		logic              out_of_range;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] pos);
		return pos & (~pos + POS_W'(1));
	endfunction

	// One add, one conditional subtract; both operands below the modulus.
	function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
	                                              input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODULUS})
			s = s - {1'b0, MODULUS};
		return s[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] mod_sub(input logic [DATA_W-1:0] a,
	                                              input logic [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		if (a >= b)
			d = {1'b0, a} - {1'b0, b};
		else
			d = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
		return d[DATA_W-1:0];
	endfunction

endpackage

### rtl/modular_fenwick_tree.sv
// Top level of the modular Fenwick tree: config register, walker, store, result register.
// Depends on mft_pkg, mft_ram and mft_walker.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   input   | in_valid / in_ready  | action, index_a, index_b, value
//   output  | out_valid / out_ready| range_sum, out_of_range
//   config  | cfg_valid / cfg_ready| tree_size
//
// Update: per visited entry a read, then a write back on the single RAM port, then a
//   closing read, the result state and the accepting idle state. Query: each prefix
//   walk reads its visited entries, drains the last read and closes; an unused
//   action goes straight to the result state.
// Clear and reset run a clearing pass over all 2048 entries, one entry per cycle; no input
//   transaction is taken meanwhile, config writes are.
// The result register lets the next transaction enter while a result waits; a held
//   output stalls the walker only when its next result is ready.
module modular_fenwick_tree
	import mft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [IDX_W-1:0]  index_a,
	input  logic [IDX_W-1:0]  index_b,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] range_sum,
	output logic              out_of_range,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] tree_size
);

	logic [SIZE_W-1:0] tree_size_q;
	cmd_t              cmd;
	mem_req_t          mem_req;
	logic [DATA_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tree_size_q <= TREE_SIZE_RST;
		else if (cfg_valid)
			tree_size_q <= tree_size;
	end

	assign cmd.action  = action;
	assign cmd.index_a = index_a;
	assign cmd.index_b = index_b;
	assign cmd.value   = value;

	mft_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (in_valid),
		.cmd       (cmd),
		.cmd_ready (in_ready),
		.tree_size (tree_size_q),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	mft_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	// Load a new result when the register is empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign range_sum    = out_q.range_sum;
	assign out_of_range = out_q.out_of_range;

endmodule

### rtl/mft_ram.sv
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
module mft_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		else
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/mft_walker.sv
// Walk sequencer: clearing pass, update read-modify-write walk, two prefix walks.
// Depends on mft_pkg; drives the port of one mft_ram.
module mft_walker
	import mft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_ready,
	input  logic [SIZE_W-1:0] tree_size,
	output mem_req_t          mem_req,
	input  logic [DATA_W-1:0] mem_rdata,
	output logic              res_valid,
	output res_t              res,
	input  logic              res_ready
);

	state_t            state_q, state_d;
	logic [POS_W-1:0]  pos_q;
	logic [IDX_W-1:0]  lo_pos_q;
	logic [IDX_W-1:0]  clr_addr_q;
	logic              clr_cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] hi_q;
	logic              rd_pend_s1;
	res_t              res_q;

	logic              accept;
	logic              clr_last;
	logic              upd_go;
	logic              walk_issue;
	logic              walk_end;
	logic              q_reject;
	logic [POS_W-1:0]  ib_plus1;
	logic [DATA_W-1:0] val_red;

	assign accept     = cmd_valid && cmd_ready;
	assign clr_last   = (32'(clr_addr_q) == CAPACITY - 1);
	assign upd_go     = (32'(pos_q) < 32'(tree_size)) && (32'(pos_q) < CAPACITY);
	assign walk_issue = (pos_q != '0);
	assign walk_end   = !walk_issue && !rd_pend_s1;
	assign ib_plus1   = POS_W'(cmd.index_b) + POS_W'(1);
	assign q_reject   = (32'(ib_plus1) >= CAPACITY);
	assign val_red    = (cmd.value >= MODULUS) ? (cmd.value - MODULUS) : cmd.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		cmd_ready     = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.addr  = pos_q[IDX_W-1:0];
		mem_req.wdata = mod_add(mem_rdata, val_q);
		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = clr_addr_q;
				mem_req.wdata = '0;
				if (clr_last)
					state_d = clr_cmd_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.action)
						ACT_UPDATE: state_d = ST_UPD_RD;
						ACT_QUERY:  state_d = q_reject ? ST_DONE : ST_Q_HI;
						ACT_CLEAR:  state_d = ST_CLEAR;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_UPD_RD: begin
				state_d = upd_go ? ST_UPD_WR : ST_DONE;
			end
			ST_UPD_WR: begin
				mem_req.we = 1'b1;
				state_d    = ST_UPD_RD;
			end
			ST_Q_HI: begin
				if (walk_end)
					state_d = ST_Q_LO;
			end
			ST_Q_LO: begin
				if (walk_end)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers of the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_cmd_q  <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= ((state_q == ST_Q_HI) || (state_q == ST_Q_LO)) && walk_issue;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (accept)
				clr_cmd_q <= (cmd.action == ACT_CLEAR);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_q              <= val_red;
					lo_pos_q           <= cmd.index_a;
					acc_q              <= '0;
					res_q.range_sum    <= '0;
					res_q.out_of_range <= (cmd.action == ACT_QUERY) && q_reject;
					if (cmd.action == ACT_QUERY)
						pos_q <= ib_plus1;
					else
						pos_q <= POS_W'(cmd.index_a) + POS_W'(1);
				end
			end
			ST_UPD_WR: begin
				pos_q <= pos_q + low_bit(pos_q);
			end
			ST_Q_HI, ST_Q_LO: begin
				if (walk_issue)
					pos_q <= pos_q - low_bit(pos_q);
				if (rd_pend_s1)
					acc_q <= mod_add(acc_q, mem_rdata);
				if (walk_end) begin
					if (state_q == ST_Q_HI) begin
						hi_q  <= acc_q;
						acc_q <= '0;
						pos_q <= POS_W'(lo_pos_q);
					end else begin
						res_q.range_sum <= mod_sub(hi_q, acc_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == ST_CLEAR || state_q == ST_UPD_WR))
		else $error("memory write outside clear or update write");

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && res_valid))
		else $error("command taken while result pending");

	a_rd_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_Q_HI || state_q == ST_Q_LO))
		else $error("pending read outside a prefix walk");

	a_sum_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.range_sum < MODULUS))
		else $error("range sum not reduced");

	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_WR) |-> $past(state_q) == ST_UPD_RD)
		else $error("update write without preceding read");

endmodule

### tb/sv/modular_fenwick_tree_checker.sv
// Checker for the modular Fenwick tree: watches the input, output and config channels,
// keeps its own copy of the tree and size register, and compares every result.
// Depends on mft_pkg.
`timescale 1ns / 100ps

module modular_fenwick_tree_checker
	import mft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [IDX_W-1:0]  index_a,
	input  logic [IDX_W-1:0]  index_b,
	input  logic [DATA_W-1:0] value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [DATA_W-1:0] range_sum,
	input  logic              out_of_range,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] tree_size,
	output int                fail_count,
	output int                pending_count
);

	logic [DATA_W-1:0] fen_store [CAPACITY];
	logic [SIZE_W-1:0] size_lim;
	res_t              sums_due [$];

	initial begin
		fail_count    = 0;
		pending_count = 0;
	end

	// Walk down by the lowest set bit, summing modulo the prime.
	function automatic int unsigned prefix_sum(input int unsigned pos);
		int unsigned acc;
		acc = 0;
		while (pos > 0 && pos < CAPACITY) begin
			acc += fen_store[pos];
			if (acc >= MODULUS)
				acc -= MODULUS;
			pos -= pos & (~pos + 1);
		end
		return acc;
	endfunction

	function automatic res_t apply_command(input cmd_t c);
		res_t        r;
		int unsigned pos;
		int unsigned amt;
		int unsigned hi;
		int unsigned lo;
		int unsigned e;
		r = '0;
		case (c.action)
			ACT_UPDATE: begin
				amt = c.value;
				if (amt >= MODULUS)
					amt -= MODULUS;
				pos = c.index_a + 1;
				while (pos < size_lim && pos < CAPACITY) begin
					e = fen_store[pos] + amt;
					if (e >= MODULUS)
						e -= MODULUS;
					fen_store[pos] = DATA_W'(e);
					pos += pos & (~pos + 1);
				end
			end
			ACT_QUERY: begin
				if (int'(c.index_b) + 1 >= CAPACITY || int'(c.index_a) >= CAPACITY) begin
					r.out_of_range = 1'b1;
				end else begin
					hi = prefix_sum(c.index_b + 1);
					lo = prefix_sum(c.index_a);
					r.range_sum = DATA_W'((hi >= lo) ? hi - lo : hi + MODULUS - lo);
				end
			end
			ACT_CLEAR: begin
				foreach (fen_store[i])
					fen_store[i] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		cmd_t cmd;
		res_t want;
		if (!arst_n) begin
			foreach (fen_store[i])
				fen_store[i] = '0;
			size_lim = TREE_SIZE_RST;
			sums_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				size_lim = tree_size;
			if (in_valid && in_ready) begin
				cmd.action  = action;
				cmd.index_a = index_a;
				cmd.index_b = index_b;
				cmd.value   = value;
				sums_due.insert(sums_due.size(), apply_command(cmd));
			end
			if (out_valid && out_ready) begin
				if (sums_due.size() == 0) begin
					$display("%0t: unexpected result: range_sum %0d out_of_range %0b",
						$time, range_sum, out_of_range);
					fail_count++;
				end else begin
					want = sums_due.pop_front();
					if (range_sum !== want.range_sum) begin
						$display("%0t: range_sum expected %0d actual %0d",
							$time, want.range_sum, range_sum);
						fail_count++;
					end
					if (out_of_range !== want.out_of_range) begin
						$display("%0t: out_of_range expected %0b actual %0b",
							$time, want.out_of_range, out_of_range);
						fail_count++;
					end
				end
			end
		end
		pending_count = sums_due.size();
	end

endmodule

### tb/sv/modular_fenwick_tree_tb.sv
// Top of the modular Fenwick tree testbench: clock, reset, directed and random traffic,
// idle and stall patterns, watchdog and verdict. Depends on mft_pkg, the block and
// modular_fenwick_tree_checker.
`timescale 1ns / 100ps

module modular_fenwick_tree_tb;
	import mft_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 600;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 215;
	localparam logic [DATA_W-1:0] VALUE_MAX = {DATA_W{1'b1}};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [ACT_W-1:0]  action;
	logic [IDX_W-1:0]  index_a;
	logic [IDX_W-1:0]  index_b;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] range_sum;
	logic              out_of_range;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] tree_size;

	int          fail_count;
	int          pending_count;
	int          quiet_cycles = 0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          holds_asked = 0;
	int          holds_done = 0;
	int unsigned hot_span = CAPACITY - 1;

	modular_fenwick_tree uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.index_a      (index_a),
		.index_b      (index_b),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.range_sum    (range_sum),
		.out_of_range (out_of_range),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.tree_size    (tree_size)
	);

	modular_fenwick_tree_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.index_a       (index_a),
		.index_b       (index_b),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.range_sum     (range_sum),
		.out_of_range  (out_of_range),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.tree_size     (tree_size),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	initial begin : sink
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end else begin
				out_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	function automatic cmd_t make_cmd(input logic [ACT_W-1:0] act, input int unsigned a,
	                                  input int unsigned b, input logic [DATA_W-1:0] v);
		cmd_t c;
		c.action  = act;
		c.index_a = IDX_W'(a);
		c.index_b = IDX_W'(b);
		c.value   = v;
		return c;
	endfunction

	function automatic cmd_t draw_command();
		cmd_t        c;
		int unsigned pick;
		int unsigned reach;
		logic [IDX_W-1:0] swap;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0: reach = CAPACITY - 1;
			1: reach = 63;
			default: reach = hot_span;
		endcase
		c.index_a = IDX_W'($urandom_range(reach));
		c.index_b = IDX_W'($urandom_range(reach));
		if (pick < 46) begin
			c.action = ACT_UPDATE;
		end else if (pick < 97) begin
			c.action = ACT_QUERY;
			// mostly ordered ranges, some reversed, some with the upper bound at capacity
			if (c.index_a > c.index_b && $urandom_range(4) != 0) begin
				swap = c.index_a;
				c.index_a = c.index_b;
				c.index_b = swap;
			end
			if ($urandom_range(9) == 0)
				c.index_b = IDX_W'(CAPACITY - 1);
		end else if (pick < 99) begin
			c.action = ACT_UNUSED;
		end else begin
			c.action = ACT_CLEAR;
		end
		case ($urandom_range(9))
			0: c.value = DATA_W'($urandom_range(VALUE_MAX, MODULUS));
			1: c.value = MODULUS - 1 - DATA_W'($urandom_range(3));
			2: c.value = DATA_W'($urandom());
			default: c.value = DATA_W'($urandom_range(MODULUS - 1));
		endcase
		return c;
	endfunction

	// Enter and leave at a falling edge; valid stays up between back-to-back transactions.
	task automatic send_item(input cmd_t c);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= c.action;
		index_a  <= c.index_a;
		index_b  <= c.index_b;
		value    <= c.value;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic write_tree_size(input logic [SIZE_W-1:0] sz);
		cfg_valid <= 1'b1;
		tree_size <= sz;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [SIZE_W-1:0] sz;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = ACT_UPDATE;
		index_a   = '0;
		index_b   = '0;
		value     = '0;
		cfg_valid = 1'b0;
		tree_size = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_tree_size(SIZE_W'(CAPACITY));
		send_item(make_cmd(ACT_QUERY, 0, CAPACITY - 2, '0));
		send_item(make_cmd(ACT_UPDATE, 0, 0, MODULUS - 1));
		send_item(make_cmd(ACT_UPDATE, CAPACITY - 2, 0, VALUE_MAX));
		send_item(make_cmd(ACT_UPDATE, CAPACITY - 1, CAPACITY - 1, 5));
		send_item(make_cmd(ACT_UPDATE, 1023, 0, MODULUS));
		send_item(make_cmd(ACT_UPDATE, 511, 0, MODULUS - 1));
		send_item(make_cmd(ACT_QUERY, 0, CAPACITY - 2, '0));
		send_item(make_cmd(ACT_QUERY, 0, CAPACITY - 1, '0));
		send_item(make_cmd(ACT_QUERY, CAPACITY - 1, 0, '0));
		send_item(make_cmd(ACT_QUERY, 5, 3, '0));
		send_item(make_cmd(ACT_QUERY, 3, 2, '0));
		send_item(make_cmd(ACT_QUERY, 0, 0, '0));
		send_item(make_cmd(ACT_UNUSED, CAPACITY - 1, CAPACITY - 1, VALUE_MAX));
		send_item(make_cmd(ACT_QUERY, 1023, 1023, '0));
		send_item(make_cmd(ACT_CLEAR, 0, 0, '0));
		send_item(make_cmd(ACT_QUERY, 0, CAPACITY - 2, '0));
		wait_results_drained();
		write_tree_size('0);
		send_item(make_cmd(ACT_UPDATE, 0, 0, 7));
		send_item(make_cmd(ACT_QUERY, 0, 5, '0));
		wait_results_drained();
		write_tree_size(SIZE_W'(1));
		send_item(make_cmd(ACT_UPDATE, 0, 0, 9));
		send_item(make_cmd(ACT_QUERY, 0, 0, '0));
		wait_results_drained();
		write_tree_size({SIZE_W{1'b1}});
		send_item(make_cmd(ACT_UPDATE, CAPACITY - 2, 0, 3));
		send_item(make_cmd(ACT_QUERY, CAPACITY - 2, CAPACITY - 2, '0));

		for (int p = 0; p < PHASES; p++) begin
			wait_results_drained();
			case (p)
				0: sz = SIZE_W'(CAPACITY);
				1: sz = {SIZE_W{1'b1}};
				2: sz = '0;
				3: sz = SIZE_W'(1);
				4: sz = SIZE_W'(17);
				5: sz = SIZE_W'(CAPACITY - 1);
				6: sz = SIZE_W'($urandom_range({SIZE_W{1'b1}}));
				default: sz = SIZE_W'(CAPACITY);
			endcase
			write_tree_size(sz);
			hot_span = (sz < 2 || sz > CAPACITY) ? CAPACITY - 1 : sz - 1;
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
				default: begin src_idle_pct = 26; sink_stall_pct = 26; end
			endcase
			// hold the result side off while items keep coming, so the input backs up
			if (p == 0)
				holds_asked++;
			repeat (PHASE_ITEMS) send_item(draw_command());
		end

		wait_results_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
rtl/mft_pkg.sv
rtl/mft_ram.sv
rtl/mft_walker.sv
rtl/modular_fenwick_tree.sv
tb/sv/modular_fenwick_tree_checker.sv
tb/sv/modular_fenwick_tree_tb.sv
